// ===== src/gfd_pkg.sv =====
package gfd_pkg;

   localparam int ROW_BITS       = 6;
   localparam int COL_BITS       = 6;
   localparam int IN_SAMPLE_BITS = 16;
   localparam int RECIP_BITS     = 16;
   localparam int DIM_BITS       = 7;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int OUT_BITS       = 25;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS_USED    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLS_USED    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECIP_STEP_X = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECIP_STEP_Y = 2'd3;

   localparam logic [DIM_BITS-1:0]   ROWS_USED_RESET = 7'd64;
   localparam logic [DIM_BITS-1:0]   COLS_USED_RESET = 7'd64;
   localparam logic [RECIP_BITS-1:0] RECIP_RESET     = 16'd256;

   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XP,
      ST_XM,
      ST_YP,
      ST_YM,
      ST_DY,
      ST_MY,
      ST_OUT
   } st_type;

   typedef struct packed {
      logic take_plus;
      logic take_diff;
      logic take_prod;
      logic take_gx;
      logic axis_y;
      logic half;
   } arith_ctl_type;

endpackage

// ===== src/gfd_grid_mem.sv =====
module gfd_grid_mem #(
   parameter int DEPTH       = 4096,
   parameter int ADDR_BITS   = 12,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [ADDR_BITS-1:0]   addr,
   input  logic [SAMPLE_BITS-1:0] wdata,
   output logic [SAMPLE_BITS-1:0] rdata
);

   logic [SAMPLE_BITS-1:0] grid_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         grid_ff[addr] <= wdata;
      end
      rdata_ff <= grid_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gfd_arith.sv =====
module gfd_arith #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  gfd_pkg::arith_ctl_type                   ctl,
   input  logic [SAMPLE_BITS-1:0]                   rd_data,
   input  logic [gfd_pkg::RECIP_BITS-1:0]           recip_x,
   input  logic [gfd_pkg::RECIP_BITS-1:0]           recip_y,
   output logic signed [gfd_pkg::OUT_BITS-1:0]      grad_x,
   output logic signed [gfd_pkg::OUT_BITS-1:0]      scaled
);

   localparam int DW = SAMPLE_BITS + 1;
   localparam int PW = DW + gfd_pkg::RECIP_BITS + 1;
   localparam logic signed [PW-1:0] SAT_MAX = PW'(gfd_pkg::OUT_MAX);
   localparam logic signed [PW-1:0] SAT_MIN = PW'(gfd_pkg::OUT_MIN);

   logic signed [SAMPLE_BITS-1:0]          rd_s;
   logic signed [SAMPLE_BITS-1:0]          plus_ff, plus_in;
   logic signed [DW-1:0]                   diff_ff, diff_in;
   logic signed [PW-1:0]                   prod_ff, prod_in;
   logic signed [gfd_pkg::OUT_BITS-1:0]    gx_ff, gx_in;
   logic [gfd_pkg::RECIP_BITS-1:0]         recip_sel;
   logic signed [PW-1:0]                   shifted;
   logic signed [gfd_pkg::OUT_BITS-1:0]    sat;

   assign rd_s = $signed(rd_data);

   // one subtractor, one multiplier and one scaler, shared by both axes
   assign recip_sel = ctl.axis_y ? recip_y : recip_x;
   assign diff_in   = ctl.take_diff ? (DW'(plus_ff) - DW'(rd_s)) : diff_ff;
   assign prod_in   = ctl.take_prod ? (PW'(diff_ff) * PW'($signed({1'b0, recip_sel})))
                                    : prod_ff;
   assign plus_in   = ctl.take_plus ? rd_s : plus_ff;

   // floor shift: 9 halves the central difference
   assign shifted = ctl.half ? (prod_ff >>> 9) : (prod_ff >>> 8);

   always_comb begin
      if (shifted > SAT_MAX) begin
         sat = gfd_pkg::OUT_MAX;
      end else if (shifted < SAT_MIN) begin
         sat = gfd_pkg::OUT_MIN;
      end else begin
         sat = shifted[gfd_pkg::OUT_BITS-1:0];
      end
   end

   assign gx_in = ctl.take_gx ? sat : gx_ff;

   always_ff @(posedge clock) begin
      plus_ff <= plus_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      gx_ff   <= gx_in;
   end

   assign grad_x = gx_ff;
   assign scaled = sat;

endmodule

// ===== src/gfd_ctrl.sv =====
module gfd_ctrl #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int ADDR_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_type,
   input  logic [gfd_pkg::ROW_BITS-1:0]      req_row,
   input  logic [gfd_pkg::COL_BITS-1:0]      req_col,
   input  logic [gfd_pkg::DIM_BITS-1:0]      rows_used,
   input  logic [gfd_pkg::DIM_BITS-1:0]      cols_used,
   input  logic                              out_free,
   output logic                              req_stall,
   output logic                              mem_we,
   output logic [ADDR_BITS-1:0]              mem_addr,
   output gfd_pkg::arith_ctl_type            ctl,
   output logic                              rsp_load,
   output logic                              oor
);

   localparam int NW_R = $clog2(MAX_ROWS + 1);
   localparam int NW_C = $clog2(MAX_COLS + 1);
   localparam int IW_R = (NW_R > gfd_pkg::DIM_BITS) ? NW_R : gfd_pkg::DIM_BITS;
   localparam int IW_C = (NW_C > gfd_pkg::DIM_BITS) ? NW_C : gfd_pkg::DIM_BITS;
   localparam logic [IW_R-1:0] MAXR = IW_R'(MAX_ROWS);
   localparam logic [IW_C-1:0] MAXC = IW_C'(MAX_COLS);
   localparam logic [IW_R-1:0] TWO_R = IW_R'(2);
   localparam logic [IW_C-1:0] TWO_C = IW_C'(2);

   gfd_pkg::st_type state_ff, state_in;

   logic [IW_R-1:0] row_ff, xp_ff, xm_ff;
   logic [IW_R-1:0] row_in, xp_in, xm_in;
   logic [IW_C-1:0] col_ff, yp_ff, ym_ff;
   logic [IW_C-1:0] col_in, yp_in, ym_in;
   logic            cen_x_ff, cen_y_ff, oor_ff;
   logic            cen_x_in, cen_y_in, oor_in;

   logic [IW_R-1:0] rows_ext, nr, req_r, row_sel;
   logic [IW_C-1:0] cols_ext, nc, req_c, col_sel;
   logic            first_r, last_r, first_c, last_c;
   logic            idle, take_query;

   assign rows_ext = IW_R'(rows_used);
   assign cols_ext = IW_C'(cols_used);
   assign nr = (rows_ext < TWO_R) ? TWO_R : ((rows_ext > MAXR) ? MAXR : rows_ext);
   assign nc = (cols_ext < TWO_C) ? TWO_C : ((cols_ext > MAXC) ? MAXC : cols_ext);
   assign req_r = IW_R'(req_row);
   assign req_c = IW_C'(req_col);

   assign idle       = (state_ff == gfd_pkg::ST_IDLE);
   assign take_query = idle && req_valid && (req_type == gfd_pkg::REQ_QUERY);

   assign first_r = (req_r == '0);
   assign last_r  = (req_r == (nr - IW_R'(1)));
   assign first_c = (req_c == '0);
   assign last_c  = (req_c == (nc - IW_C'(1)));

   // neighbor indexes: one-sided at the edges, central inside
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      xp_in    = xp_ff;
      xm_in    = xm_ff;
      yp_in    = yp_ff;
      ym_in    = ym_ff;
      cen_x_in = cen_x_ff;
      cen_y_in = cen_y_ff;
      oor_in   = oor_ff;
      if (take_query) begin
         row_in   = req_r;
         col_in   = req_c;
         xp_in    = last_r  ? req_r : req_r + IW_R'(1);
         xm_in    = first_r ? req_r : req_r - IW_R'(1);
         yp_in    = last_c  ? req_c : req_c + IW_C'(1);
         ym_in    = first_c ? req_c : req_c - IW_C'(1);
         cen_x_in = !first_r && !last_r;
         cen_y_in = !first_c && !last_c;
         oor_in   = (req_r >= nr) || (req_c >= nc);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfd_pkg::ST_IDLE: begin
            if (take_query) begin
               state_in = oor_in ? gfd_pkg::ST_OUT : gfd_pkg::ST_XP;
            end
         end
         gfd_pkg::ST_XP:  state_in = gfd_pkg::ST_XM;
         gfd_pkg::ST_XM:  state_in = gfd_pkg::ST_YP;
         gfd_pkg::ST_YP:  state_in = gfd_pkg::ST_YM;
         gfd_pkg::ST_YM:  state_in = gfd_pkg::ST_DY;
         gfd_pkg::ST_DY:  state_in = gfd_pkg::ST_MY;
         gfd_pkg::ST_MY:  state_in = gfd_pkg::ST_OUT;
         gfd_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = gfd_pkg::ST_IDLE;
            end
         end
         default: state_in = gfd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl      = '0;
      row_sel  = row_ff;
      col_sel  = col_ff;
      rsp_load = 1'b0;
      case (state_ff)
         gfd_pkg::ST_IDLE: begin
            row_sel = req_r;
            col_sel = req_c;
         end
         gfd_pkg::ST_XP: row_sel = xp_ff;
         gfd_pkg::ST_XM: begin
            row_sel       = xm_ff;
            ctl.take_plus = 1'b1;
         end
         gfd_pkg::ST_YP: begin
            col_sel       = yp_ff;
            ctl.take_diff = 1'b1;
         end
         gfd_pkg::ST_YM: begin
            col_sel       = ym_ff;
            ctl.take_plus = 1'b1;
            ctl.take_prod = 1'b1;
         end
         gfd_pkg::ST_DY: begin
            ctl.take_diff = 1'b1;
            ctl.take_gx   = 1'b1;
            ctl.half      = cen_x_ff;
         end
         gfd_pkg::ST_MY: begin
            ctl.take_prod = 1'b1;
            ctl.axis_y    = 1'b1;
         end
         gfd_pkg::ST_OUT: begin
            ctl.half = cen_y_ff;
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   assign req_stall = !idle;
   assign mem_we    = idle && req_valid && (req_type == gfd_pkg::REQ_WRITE) &&
                      (req_r < MAXR) && (req_c < MAXC);
   assign mem_addr  = ADDR_BITS'(row_sel) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(col_sel);
   assign oor       = oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      xp_ff    <= xp_in;
      xm_ff    <= xm_in;
      yp_ff    <= yp_in;
      ym_ff    <= ym_in;
      cen_x_ff <= cen_x_in;
      cen_y_ff <= cen_y_in;
      oor_ff   <= oor_in;
   end

endmodule

// ===== src/grid_gradient_finite_difference.sv =====
// Channel  Direction  Handshake           Beat contents
// req      in         req_valid/stall     req_type, req_row, req_col, req_sample
// rsp      out        rsp_valid/stall     rsp_grad_x, rsp_grad_y, rsp_out_of_range
// csr      in         csr_write           csr_index, csr_data
//
// A write beat does not hold off the next beat. An in-range query makes four reads
// of the single-port grid memory that feed one shared subtract, multiply and scale
// unit; a query outside the used grid skips the reads.
// The result register lets a new beat be taken while a result waits; a query only
// holds in its last step while the previous result is still stalled.
// Synchronous reset clears control and rsp_valid, presets CSRs; grid stays unknown.
module grid_gradient_finite_difference #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_type,
   input  logic [gfd_pkg::ROW_BITS-1:0]               req_row,
   input  logic [gfd_pkg::COL_BITS-1:0]               req_col,
   input  logic signed [gfd_pkg::IN_SAMPLE_BITS-1:0]  req_sample,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [gfd_pkg::OUT_BITS-1:0]        rsp_grad_x,
   output logic signed [gfd_pkg::OUT_BITS-1:0]        rsp_grad_y,
   output logic                                       rsp_out_of_range,
   input  logic                                       csr_write,
   input  logic [gfd_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [gfd_pkg::CSR_DATA_BITS-1:0]          csr_data
);

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS = $clog2(DEPTH);

   logic [gfd_pkg::DIM_BITS-1:0]   rows_used_ff, rows_used_in;
   logic [gfd_pkg::DIM_BITS-1:0]   cols_used_ff, cols_used_in;
   logic [gfd_pkg::RECIP_BITS-1:0] recip_x_ff, recip_x_in;
   logic [gfd_pkg::RECIP_BITS-1:0] recip_y_ff, recip_y_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [gfd_pkg::OUT_BITS-1:0]  grad_x_ff, grad_x_in;
   logic signed [gfd_pkg::OUT_BITS-1:0]  grad_y_ff, grad_y_in;
   logic                                 oor_out_ff, oor_out_in;

   logic                          out_free;
   logic                          mem_we;
   logic [ADDR_BITS-1:0]          mem_addr;
   logic [SAMPLE_BITS-1:0]        mem_wdata;
   logic [SAMPLE_BITS-1:0]        mem_rdata;
   gfd_pkg::arith_ctl_type        ctl;
   logic                          rsp_load;
   logic                          oor;
   logic signed [gfd_pkg::OUT_BITS-1:0] gx;
   logic signed [gfd_pkg::OUT_BITS-1:0] gy;

   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      recip_x_in   = recip_x_ff;
      recip_y_in   = recip_y_ff;
      if (csr_write) begin
         case (csr_index)
            gfd_pkg::CSR_ROWS_USED:    rows_used_in = csr_data[gfd_pkg::DIM_BITS-1:0];
            gfd_pkg::CSR_COLS_USED:    cols_used_in = csr_data[gfd_pkg::DIM_BITS-1:0];
            gfd_pkg::CSR_RECIP_STEP_X: recip_x_in   = csr_data[gfd_pkg::RECIP_BITS-1:0];
            gfd_pkg::CSR_RECIP_STEP_Y: recip_y_in   = csr_data[gfd_pkg::RECIP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= gfd_pkg::ROWS_USED_RESET;
         cols_used_ff <= gfd_pkg::COLS_USED_RESET;
         recip_x_ff   <= gfd_pkg::RECIP_RESET;
         recip_y_ff   <= gfd_pkg::RECIP_RESET;
      end else begin
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         recip_x_ff   <= recip_x_in;
         recip_y_ff   <= recip_y_in;
      end
   end

   // truncate or sign-extend to the stored width
   assign mem_wdata = SAMPLE_BITS'(req_sample);

   gfd_grid_mem #(
      .DEPTH       (DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   gfd_ctrl #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ADDR_BITS (ADDR_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_row   (req_row),
      .req_col   (req_col),
      .rows_used (rows_used_ff),
      .cols_used (cols_used_ff),
      .out_free  (out_free),
      .req_stall (req_stall),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .ctl       (ctl),
      .rsp_load  (rsp_load),
      .oor       (oor)
   );

   gfd_arith #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_arith (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (mem_rdata),
      .recip_x (recip_x_ff),
      .recip_y (recip_y_ff),
      .grad_x  (gx),
      .scaled  (gy)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      grad_x_in    = grad_x_ff;
      grad_y_in    = grad_y_ff;
      oor_out_in   = oor_out_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         grad_x_in    = oor ? '0 : gx;
         grad_y_in    = oor ? '0 : gy;
         oor_out_in   = oor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grad_x_ff  <= grad_x_in;
      grad_y_ff  <= grad_y_in;
      oor_out_ff <= oor_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grad_x       = grad_x_ff;
   assign rsp_grad_y       = grad_y_ff;
   assign rsp_out_of_range = oor_out_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_grad_x == '0 && rsp_grad_y == '0)
      else $error("out-of-range result carries a nonzero gradient");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == gfd_pkg::REQ_QUERY |=> req_stall)
      else $error("query beat did not hold off the next beat");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == gfd_pkg::REQ_WRITE |=> !req_stall)
      else $error("write beat stalled the next beat");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(rsp_load))
      else $error("result appeared without a finished query");

endmodule
